// ----- sv/pressure_temperature_compensation_defines.svh -----
// Assertion macros for the compensation block.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`ifndef ASSERT_OFF
`define PTC_ASSERT_IMPL(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PTC_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define PTC_ASSERT_IMPL(label, prop)
`define PTC_ASSERT_NEXT(label, a, b)
`endif
`endif

// ----- sv/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

    typedef struct packed {
        logic        opcode;
        logic [19:0] raw_sample;
    } in_beat_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] temperature_centi;
        logic [31:0] pressure_pa;
        logic        divide_error;
    } out_beat_t;

    localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
    localparam logic [1:0] REG_PRESS_LO  = 2'd1;
    localparam logic [1:0] REG_PRESS_MID = 2'd2;
    localparam logic [1:0] REG_PRESS_HI  = 2'd3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

endpackage

// ----- sv/ptc_stream_if.sv -----
// ----------------------------------------------------------------------------
// ptc_in_if / ptc_out_if
// Valid/ready channels carrying input and result beats.
// ----------------------------------------------------------------------------
interface ptc_in_if;
    logic              valid;
    logic              ready;
    ptc_pkg::in_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ptc_out_if;
    logic               valid;
    logic               ready;
    ptc_pkg::out_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ptc_serial_mul.sv -----
// ----------------------------------------------------------------------------
// ptc_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, low 32 product bits.
// ----------------------------------------------------------------------------
module ptc_serial_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] product
);
    import ptc_pkg::*;

    logic [31:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    // one partial product per cycle; operands shift so the add stays fixed
    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mcand_next  = a;
            mplier_next = b;
            acc_next    = '0;
            cnt_next    = 6'd0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = {mcand_reg[30:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[31:1]};
            cnt_next    = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

// ----- sv/ptc_serial_div.sv -----
// ----------------------------------------------------------------------------
// ptc_serial_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptc_serial_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import ptc_pkg::*;

    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [33:0] diff;

    // shift one dividend bit into the remainder, try the subtract
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[31]};
        diff      = {1'b0, trial} - {2'b00, dvs_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- sv/pressure_temperature_compensation.sv -----
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Integer temperature/pressure compensation with a sequenced datapath.
// ----------------------------------------------------------------------------
// One item at a time. A temperature beat takes three multiplies; a pressure
// beat takes ten multiplies and one divide, or seven multiplies and no divide
// when the divisor is zero. Each multiply and the divide consist of a start,
// 32 one-bit iterations in a shared shift-add multiplier or a restoring
// divider, and a hand-back of the result. A small sequencer walks the formula
// one step at a time. The result sits in an output register; the next beat is
// accepted the cycle after the result is taken, so the block takes no new beat
// until the result of the last one has been taken.
module pressure_temperature_compensation
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_data,
    ptc_in_if.sink                             in_ch,
    ptc_out_if.source                          out_ch
);
    import ptc_pkg::*;
`include "pressure_temperature_compensation_defines.svh"

    // sequencer steps
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_T1   = 5'd1;  // a = (adc>>3 - t1<<1)*t2
    localparam logic [4:0] S_T2   = 5'd2;  // d*d
    localparam logic [4:0] S_T3   = 5'd3;  // (dd>>12)*t3
    localparam logic [4:0] S_T4   = 5'd4;  // finish temperature
    localparam logic [4:0] S_P1   = 5'd5;  // q*q
    localparam logic [4:0] S_P2   = 5'd6;  // (qq>>11)*p6
    localparam logic [4:0] S_P3   = 5'd7;  // v1*p5
    localparam logic [4:0] S_P4   = 5'd8;  // p3*(qq>>13)
    localparam logic [4:0] S_P5   = 5'd9;  // p2*v1
    localparam logic [4:0] S_P6   = 5'd10; // (32768+v1)*p1
    localparam logic [4:0] S_P7   = 5'd11; // base*3125
    localparam logic [4:0] S_P8   = 5'd12; // divide
    localparam logic [4:0] S_P9   = 5'd13; // q*q
    localparam logic [4:0] S_P10  = 5'd14; // p9*(qq>>13)
    localparam logic [4:0] S_P11  = 5'd15; // (p>>2)*p8
    localparam logic [4:0] S_P12  = 5'd16; // final sum
    localparam logic [4:0] S_OUT  = 5'd17;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_lo_reg, press_mid_reg;
    logic [15:0] press_hi_reg;
    logic [31:0] temp_fine_reg;

    logic [4:0]  state_reg, state_next;
    logic        wait_reg, wait_next;
    logic [19:0] adc_reg;
    logic [31:0] x_reg, x_next;   // scratch: a, v1, p
    logic [31:0] y_reg, y_next;   // scratch: qq, v2
    logic [31:0] z_reg, z_next;   // scratch: q, v2 partial
    logic        ov_reg, ov_next; // divide path: result then doubled
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_reg, out_next;

    logic        mul_start, div_start, mul_done, div_done;
    logic [31:0] mul_a, mul_b, mul_p, div_n, div_d, div_q;

    // calibration slices
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, temp_cal_reg[15:0]};
    assign t2 = {{16{temp_cal_reg[31]}}, temp_cal_reg[31:16]};
    assign t3 = {{16{temp_cal_reg[47]}}, temp_cal_reg[47:32]};
    assign p1 = {16'd0, press_lo_reg[15:0]};
    assign p2 = {{16{press_lo_reg[31]}}, press_lo_reg[31:16]};
    assign p3 = {{16{press_lo_reg[47]}}, press_lo_reg[47:32]};
    assign p4 = {{16{press_lo_reg[63]}}, press_lo_reg[63:48]};
    assign p5 = {{16{press_mid_reg[15]}}, press_mid_reg[15:0]};
    assign p6 = {{16{press_mid_reg[31]}}, press_mid_reg[31:16]};
    assign p7 = {{16{press_mid_reg[47]}}, press_mid_reg[47:32]};
    assign p8 = {{16{press_mid_reg[63]}}, press_mid_reg[63:48]};
    assign p9 = {{16{press_hi_reg[15]}}, press_hi_reg[15:0]};

    logic [31:0] adc32, tf_half, v1_init, q_init, fine, tc, pbase, mq;
    assign adc32   = {12'd0, adc_reg};
    assign tf_half = $signed(temp_fine_reg) >>> 1;
    assign v1_init = tf_half - 32'd64000;
    assign q_init  = $signed(v1_init) >>> 2;
    assign fine    = x_reg + $unsigned($signed(mul_p) >>> 14);
    assign tc      = $signed(fine * 32'd5 + 32'd128) >>> 8;
    assign pbase   = (32'd1048576 - adc32) - $unsigned($signed(y_reg) >>> 12);
    assign mq      = div_q;

    logic [31:0] v1a, v1b;
    assign v1a = ($signed(($signed(z_reg) >>> 3) + ($signed(mul_p) >>> 1))) >>> 18;
    assign v1b = 32'd32768 + v1a;

    ptc_serial_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    ptc_serial_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ch.ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // sequencer: each step launches at most one operation and consumes its result
    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        ov_next        = ov_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_n          = '0;
        div_d          = x_reg;
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = (in_ch.data.opcode == OP_TEMP) ? S_T1 : S_P1;
                    wait_next  = 1'b0;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                if (!wait_reg)
                begin
                    wait_next = 1'b1;
                    if (state_reg == S_P8)
                        div_start = 1'b1;
                    else if (state_reg != S_P12 && state_reg != S_T4)
                        mul_start = 1'b1;
                end
                // operand selection, held across the whole operation
                unique case (state_reg)
                    S_T1:
                    begin
                        mul_a = (adc32 >> 3) - (t1 << 1);
                        mul_b = t2;
                    end
                    S_T2:
                    begin
                        mul_a = (adc32 >> 4) - t1;
                        mul_b = (adc32 >> 4) - t1;
                    end
                    S_T3:
                    begin
                        mul_a = y_reg;
                        mul_b = t3;
                    end
                    S_P1:
                    begin
                        mul_a = q_init;
                        mul_b = q_init;
                    end
                    S_P2:
                    begin
                        mul_a = $signed(y_reg) >>> 11;
                        mul_b = p6;
                    end
                    S_P3:
                    begin
                        mul_a = v1_init;
                        mul_b = p5;
                    end
                    S_P4:
                    begin
                        mul_a = p3;
                        mul_b = $signed(y_reg) >>> 13;
                    end
                    S_P5:
                    begin
                        mul_a = p2;
                        mul_b = v1_init;
                    end
                    S_P6:
                    begin
                        mul_a = x_reg;
                        mul_b = p1;
                    end
                    S_P7:
                    begin
                        mul_a = z_reg;
                        mul_b = 32'd3125;
                    end
                    S_P8:
                    begin
                        div_n = ov_reg ? y_reg : {y_reg[30:0], 1'b0};
                        div_d = x_reg;
                    end
                    S_P9:
                    begin
                        mul_a = x_reg >> 3;
                        mul_b = x_reg >> 3;
                    end
                    S_P10:
                    begin
                        mul_a = p9;
                        mul_b = y_reg >> 13;
                    end
                    S_P11:
                    begin
                        mul_a = x_reg >> 2;
                        mul_b = p8;
                    end
                    default:
                    begin
                        mul_a = '0;
                    end
                endcase
                // completion of the step
                if (wait_reg && (mul_done || div_done || state_reg == S_P12
                                 || state_reg == S_T4))
                begin
                    wait_next = 1'b0;
                    unique case (state_reg)
                        S_T1:
                        begin
                            x_next     = $signed(mul_p) >>> 11;
                            state_next = S_T2;
                        end
                        S_T2:
                        begin
                            y_next     = $signed(mul_p) >>> 12;
                            state_next = S_T3;
                        end
                        S_T3:
                        begin
                            x_next     = fine;
                            out_next.result_kind       = OP_TEMP;
                            out_next.temperature_centi = tc;
                            out_next.pressure_pa       = '0;
                            out_next.divide_error      = 1'b0;
                            state_next = S_T4;
                        end
                        S_T4:
                        begin
                            state_next = S_OUT;
                        end
                        S_P1:
                        begin
                            y_next     = mul_p;
                            state_next = S_P2;
                        end
                        S_P2:
                        begin
                            z_next     = mul_p;
                            state_next = S_P3;
                        end
                        S_P3:
                        begin
                            // v2 = (v2 + (v1*p5)<<1) >>> 2 + p4<<16
                            z_next = $unsigned($signed(z_reg + {mul_p[30:0], 1'b0}) >>> 2)
                                     + (p4 << 16);
                            state_next = S_P4;
                        end
                        S_P4:
                        begin
                            // keep v2 in x while p3 term goes to z
                            x_next     = z_reg;
                            z_next     = mul_p;
                            state_next = S_P5;
                        end
                        S_P5:
                        begin
                            y_next     = x_reg;
                            x_next     = v1b;
                            state_next = S_P6;
                        end
                        S_P6:
                        begin
                            x_next     = $signed(mul_p) >>> 15;
                            z_next     = pbase;
                            state_next = S_P7;
                        end
                        S_P7:
                        begin
                            y_next  = mul_p;
                            ov_next = mul_p[31];
                            if (x_reg == '0)
                            begin
                                out_next.result_kind       = OP_PRESS;
                                out_next.temperature_centi = '0;
                                out_next.pressure_pa       = '0;
                                out_next.divide_error      = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                                state_next = S_P8;
                        end
                        S_P8:
                        begin
                            x_next     = ov_reg ? {mq[30:0], 1'b0} : mq;
                            state_next = S_P9;
                        end
                        S_P9:
                        begin
                            y_next     = mul_p;
                            state_next = S_P10;
                        end
                        S_P10:
                        begin
                            z_next     = $signed(mul_p) >>> 12;
                            state_next = S_P11;
                        end
                        S_P11:
                        begin
                            y_next     = $signed(mul_p) >>> 13;
                            state_next = S_P12;
                        end
                        S_P12:
                        begin
                            out_next.result_kind       = OP_PRESS;
                            out_next.temperature_centi = '0;
                            out_next.pressure_pa       = x_reg
                                + $unsigned($signed(z_reg + y_reg + p7) >>> 4);
                            out_next.divide_error      = 1'b0;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
        endcase
        if (state_reg == S_OUT)
            out_valid_next = 1'b1;
    end

    // control, calibration and fine temperature registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            temp_fine_reg <= '0;
            temp_cal_reg  <= '0;
            press_lo_reg  <= '0;
            press_mid_reg <= '0;
            press_hi_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_T4)
                temp_fine_reg <= x_reg;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TEMP_CAL:  temp_cal_reg  <= cfg_data[47:0];
                    REG_PRESS_LO:  press_lo_reg  <= cfg_data;
                    REG_PRESS_MID: press_mid_reg <= cfg_data;
                    REG_PRESS_HI:  press_hi_reg  <= cfg_data[15:0];
                    default:       press_hi_reg  <= press_hi_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        ov_reg  <= ov_next;
        out_reg <= out_next;
        if (in_ch.valid && in_ch.ready)
            adc_reg <= in_ch.data.raw_sample;
    end

    `PTC_ASSERT_IMPL(a_no_accept_busy, (in_ch.valid && in_ch.ready) |-> !out_valid_reg)
    `PTC_ASSERT_NEXT(a_out_after_done, (state_reg == S_OUT), out_valid_reg)
    `PTC_ASSERT_IMPL(a_one_unit, !(mul_start && div_start))
endmodule
